FILE: rtl/ntsc_pkg.sv
// ----------------------------------------------------------------------------
// ntsc_pkg
// shared widths, codes and the transaction record that walks the seed chain
// ----------------------------------------------------------------------------
package ntsc_pkg;

    localparam int NUM_SEEDS_DEF = 24;

    localparam int SLOT_W  = 5;
    localparam int POS_W   = 16;
    localparam int COL_W   = 3;
    localparam int CELL_W  = 8;
    localparam int SIZE_W  = 5;
    localparam int THR_W   = 16;
    localparam int CLS_W   = 2;
    localparam int CTR_W   = 17;              // cell centre, q13.4, up to 126728
    localparam int SQ_W    = 2 * CTR_W;       // one squared axis distance
    localparam int DSQ_W   = SQ_W + 1;        // squared euclidean distance
    localparam int ROOT_W  = (DSQ_W + 1) / 2; // floor root width
    localparam int REM_W   = ROOT_W + 2;      // root remainder width

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int RES_W      = SLOT_W + COL_W + CLS_W + THR_W;

    // register indexes
    localparam logic [2:0] REG_SEEDS_IN_USE = 3'd0;
    localparam logic [2:0] REG_CELL_WIDTH   = 3'd1;
    localparam logic [2:0] REG_CELL_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_BORDER_THR   = 3'd3;
    localparam logic [2:0] REG_CENTRE_THR   = 3'd4;

    // commands
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // cell classes
    localparam logic [CLS_W-1:0] CLS_INTERIOR = 2'd0;
    localparam logic [CLS_W-1:0] CLS_BORDER   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_CENTRE   = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  sx;
        logic [POS_W-1:0]  sy;
        logic [COL_W-1:0]  scol;
        logic [CTR_W-1:0]  cx;
        logic [CTR_W-1:0]  cy;
        logic [DSQ_W-1:0]  d1sq;
        logic [DSQ_W-1:0]  d2sq;
        logic [SLOT_W-1:0] best;
        logic [COL_W-1:0]  bcol;
    } t_token;

    typedef struct packed {
        logic [SLOT_W-1:0] best;
        logic [COL_W-1:0]  bcol;
    } t_side;

endpackage

FILE: rtl/nearest_two_seed_classifier.sv
// ----------------------------------------------------------------------------
// nearest_two_seed_classifier
// output: each classify gives one result on the result stream; a load gives
//   no result
// throughput: one transaction per cycle, set by the two-stage seed cells and
//   the one-bit-per-stage root pipe; only a full output buffer holds it back
// reset: synchronous active-low, clears all valid bits and loads register
//   defaults; the seed slots keep whatever they held until loaded
// ----------------------------------------------------------------------------
module nearest_two_seed_classifier #(
    parameter int NUM_SEEDS = ntsc_pkg::NUM_SEEDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // seed_slot[4:0], seed_x[20:5], seed_y[36:21], seed_colour[39:37],
    // cell_col[47:40], cell_row[55:48]
    input  logic [ntsc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd[0]
    input  logic                               s_axis_tuser,

    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // nearest_slot[4:0], nearest_colour[7:5], cell_class[9:8],
    // nearest_distance[25:10], zero fill above
    output logic [ntsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,

    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [ntsc_pkg::SIZE_W-1:0] r_seeds_in_use;
    logic [ntsc_pkg::SIZE_W-1:0] r_cell_w;
    logic [ntsc_pkg::SIZE_W-1:0] r_cell_h;
    logic [ntsc_pkg::THR_W-1:0]  r_border_thr;
    logic [ntsc_pkg::THR_W-1:0]  r_centre_thr;

    logic       w_cfg_wr;
    logic [2:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeds_in_use <= 5'd24;
            r_cell_w       <= 5'd8;
            r_cell_h       <= 5'd16;
            r_border_thr   <= 16'd240;
            r_centre_thr   <= 16'd192;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                ntsc_pkg::REG_SEEDS_IN_USE: r_seeds_in_use <= pwdata[4:0];
                ntsc_pkg::REG_CELL_WIDTH:   r_cell_w       <= pwdata[4:0];
                ntsc_pkg::REG_CELL_HEIGHT:  r_cell_h       <= pwdata[4:0];
                ntsc_pkg::REG_BORDER_THR:   r_border_thr   <= pwdata[15:0];
                ntsc_pkg::REG_CENTRE_THR:   r_centre_thr   <= pwdata[15:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            ntsc_pkg::REG_SEEDS_IN_USE: prdata = {27'd0, r_seeds_in_use};
            ntsc_pkg::REG_CELL_WIDTH:   prdata = {27'd0, r_cell_w};
            ntsc_pkg::REG_CELL_HEIGHT:  prdata = {27'd0, r_cell_h};
            ntsc_pkg::REG_BORDER_THR:   prdata = {16'd0, r_border_thr};
            ntsc_pkg::REG_CENTRE_THR:   prdata = {16'd0, r_centre_thr};
            default:                    prdata = 32'd0;
        endcase
    end

    // scan length, held between two and the table depth
    logic [ntsc_pkg::SLOT_W-1:0] w_seed_count;

    always_comb begin
        if (r_seeds_in_use < 5'd2) begin
            w_seed_count = 5'd2;
        end else if (32'(r_seeds_in_use) > NUM_SEEDS) begin
            w_seed_count = ntsc_pkg::SLOT_W'(NUM_SEEDS);
        end else begin
            w_seed_count = r_seeds_in_use;
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: the whole chain moves while the output buffer has
    // a free entry, so a single waiting result does not block new transactions
    // ------------------------------------------------------------------
    logic [1:0] r_count;
    logic       w_en;

    assign w_en          = (r_count != 2'd2);
    assign s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // entry stage: unpack, cell centre, seed the running minima
    // centre = (2*col + 1) * size * 8 in q13.4
    // ------------------------------------------------------------------
    logic             r_ent_vld;
    ntsc_pkg::t_token r_ent_tok;
    ntsc_pkg::t_token n_ent_tok;
    logic [13:0]      w_prod_x;
    logic [13:0]      w_prod_y;

    assign w_prod_x = {5'd0, s_axis_tdata[47:40], 1'b1} * {9'd0, r_cell_w};
    assign w_prod_y = {5'd0, s_axis_tdata[55:48], 1'b1} * {9'd0, r_cell_h};

    always_comb begin
        n_ent_tok      = '0;
        n_ent_tok.cmd  = s_axis_tuser;
        n_ent_tok.slot = s_axis_tdata[4:0];
        n_ent_tok.sx   = s_axis_tdata[20:5];
        n_ent_tok.sy   = s_axis_tdata[36:21];
        n_ent_tok.scol = s_axis_tdata[39:37];
        n_ent_tok.cx   = {w_prod_x, 3'b000};
        n_ent_tok.cy   = {w_prod_y, 3'b000};
        n_ent_tok.d1sq = '1;
        n_ent_tok.d2sq = '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= 1'b0;
        end else if (w_en) begin
            r_ent_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ent_tok <= n_ent_tok;
        end
    end

    // ------------------------------------------------------------------
    // seed chain: loads write their slot on the way through, so each
    // query sees exactly the loads taken before it
    // ------------------------------------------------------------------
    logic             w_chain_vld [NUM_SEEDS];
    ntsc_pkg::t_token w_chain_tok [NUM_SEEDS];

    for (genvar k = 0; k < NUM_SEEDS; k++) begin : g_cell
        logic             w_in_vld;
        ntsc_pkg::t_token w_in_tok;

        if (k == 0) begin : g_first
            assign w_in_vld = r_ent_vld;
            assign w_in_tok = r_ent_tok;
        end else begin : g_next
            assign w_in_vld = w_chain_vld[k-1];
            assign w_in_tok = w_chain_tok[k-1];
        end

        ntsc_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_en),
            .i_seed_count (w_seed_count),
            .i_vld        (w_in_vld),
            .i_tok        (w_in_tok),
            .o_vld        (w_chain_vld[k]),
            .o_tok        (w_chain_tok[k])
        );
    end

    // ------------------------------------------------------------------
    // square roots, queries only
    // ------------------------------------------------------------------
    ntsc_pkg::t_token              w_tail_tok;
    logic                          w_root_in_vld;
    ntsc_pkg::t_side               w_root_in_side;
    logic                          w_sq_vld;
    logic [ntsc_pkg::ROOT_W-1:0]   w_d1;
    logic [ntsc_pkg::ROOT_W-1:0]   w_d2;
    ntsc_pkg::t_side               w_sq_side;

    assign w_tail_tok          = w_chain_tok[NUM_SEEDS-1];
    assign w_root_in_vld       = w_chain_vld[NUM_SEEDS-1]
                                 && (w_tail_tok.cmd == ntsc_pkg::CMD_CLASSIFY);
    assign w_root_in_side.best = w_tail_tok.best;
    assign w_root_in_side.bcol = w_tail_tok.bcol;

    ntsc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_root_in_vld),
        .i_d1sq  (w_tail_tok.d1sq),
        .i_d2sq  (w_tail_tok.d2sq),
        .i_side  (w_root_in_side),
        .o_vld   (w_sq_vld),
        .o_d1    (w_d1),
        .o_d2    (w_d2),
        .o_side  (w_sq_side)
    );

    // ------------------------------------------------------------------
    // classify on the unsaturated roots, saturate only the reported distance
    // ------------------------------------------------------------------
    logic [ntsc_pkg::ROOT_W-1:0] w_gap;
    logic [ntsc_pkg::CLS_W-1:0]  w_class;
    logic [ntsc_pkg::THR_W-1:0]  w_dist;
    logic [ntsc_pkg::RES_W-1:0]  w_result;

    assign w_gap = w_d2 - w_d1;

    always_comb begin
        if (w_d1 < {2'b00, r_centre_thr}) begin
            w_class = ntsc_pkg::CLS_CENTRE;
        end else if (w_gap < {2'b00, r_border_thr}) begin
            w_class = ntsc_pkg::CLS_BORDER;
        end else begin
            w_class = ntsc_pkg::CLS_INTERIOR;
        end
    end

    assign w_dist   = (|w_d1[ntsc_pkg::ROOT_W-1:ntsc_pkg::THR_W]) ? '1
                      : w_d1[ntsc_pkg::THR_W-1:0];
    assign w_result = {w_dist, w_class, w_sq_side.bcol, w_sq_side.best};

    // ------------------------------------------------------------------
    // two-entry output buffer
    // ------------------------------------------------------------------
    logic [ntsc_pkg::RES_W-1:0] r_buf [2];
    logic                       r_wr_ptr;
    logic                       r_rd_ptr;
    logic                       w_push;
    logic                       w_pop;

    assign w_push = w_sq_vld && w_en;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_result;
        end
    end

    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = {{(ntsc_pkg::OUT_DATA_W - ntsc_pkg::RES_W){1'b0}},
                            r_buf[r_rd_ptr]};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && (r_count == 2'd2)))
        else $error("result pushed into a full output buffer");

    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_vld |-> (w_d1 <= w_d2))
        else $error("nearest distance above second distance");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[4:0]) < NUM_SEEDS))
        else $error("nearest slot outside the table");

    a_entry_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_ent_vld)
        else $error("accepted transaction missing from entry stage");

endmodule

FILE: rtl/ntsc_cell.sv
// ----------------------------------------------------------------------------
// ntsc_cell
// one seed slot: holds its seed, squares the axis offsets, then updates the
// running nearest and second-nearest of a passing query
// ----------------------------------------------------------------------------
module ntsc_cell #(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [ntsc_pkg::SLOT_W-1:0]  i_seed_count,
    input  logic                         i_vld,
    input  ntsc_pkg::t_token             i_tok,
    output logic                         o_vld,
    output ntsc_pkg::t_token             o_tok
);

    logic [ntsc_pkg::POS_W-1:0] r_seed_x;
    logic [ntsc_pkg::POS_W-1:0] r_seed_y;
    logic [ntsc_pkg::COL_W-1:0] r_seed_col;

    logic                       r_a_vld;
    ntsc_pkg::t_token           r_a_tok;
    logic [ntsc_pkg::SQ_W-1:0]  r_a_sqx;
    logic [ntsc_pkg::SQ_W-1:0]  r_a_sqy;
    logic [ntsc_pkg::COL_W-1:0] r_a_col;

    logic                       r_b_vld;
    ntsc_pkg::t_token           r_b_tok;

    logic [ntsc_pkg::CTR_W-1:0] w_dx;
    logic [ntsc_pkg::CTR_W-1:0] w_dy;
    logic [ntsc_pkg::CTR_W-1:0] w_x_ext;
    logic [ntsc_pkg::CTR_W-1:0] w_y_ext;
    logic [ntsc_pkg::DSQ_W-1:0] w_dsum;
    logic                       w_load_here;
    logic                       w_active;
    ntsc_pkg::t_token           n_b_tok;

    assign w_x_ext = {1'b0, r_seed_x};
    assign w_y_ext = {1'b0, r_seed_y};
    assign w_dx = (i_tok.cx >= w_x_ext) ? (i_tok.cx - w_x_ext) : (w_x_ext - i_tok.cx);
    assign w_dy = (i_tok.cy >= w_y_ext) ? (i_tok.cy - w_y_ext) : (w_y_ext - i_tok.cy);

    assign w_load_here = i_vld && (i_tok.cmd == ntsc_pkg::CMD_LOAD)
                         && (32'(i_tok.slot) == IDX);

    // seed store, written as the load passes
    always_ff @(posedge i_clk) begin
        if (i_en && w_load_here) begin
            r_seed_x   <= i_tok.sx;
            r_seed_y   <= i_tok.sy;
            r_seed_col <= i_tok.scol;
        end
    end

    // stage a: axis squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tok <= i_tok;
            r_a_sqx <= {{ntsc_pkg::CTR_W{1'b0}}, w_dx} * {{ntsc_pkg::CTR_W{1'b0}}, w_dx};
            r_a_sqy <= {{ntsc_pkg::CTR_W{1'b0}}, w_dy} * {{ntsc_pkg::CTR_W{1'b0}}, w_dy};
            r_a_col <= r_seed_col;
        end
    end

    // stage b: sum and keep the two smallest, first seed wins on ties
    assign w_dsum   = {1'b0, r_a_sqx} + {1'b0, r_a_sqy};
    assign w_active = (r_a_tok.cmd == ntsc_pkg::CMD_CLASSIFY)
                      && (32'(i_seed_count) > IDX);

    always_comb begin
        n_b_tok = r_a_tok;
        if (w_active) begin
            if (w_dsum < r_a_tok.d1sq) begin
                n_b_tok.d2sq = r_a_tok.d1sq;
                n_b_tok.d1sq = w_dsum;
                n_b_tok.best = ntsc_pkg::SLOT_W'(IDX);
                n_b_tok.bcol = r_a_col;
            end else if (w_dsum < r_a_tok.d2sq) begin
                n_b_tok.d2sq = w_dsum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_tok <= n_b_tok;
        end
    end

    assign o_vld = r_b_vld;
    assign o_tok = r_b_tok;

endmodule

FILE: rtl/ntsc_isqrt.sv
// ----------------------------------------------------------------------------
// ntsc_isqrt
// pipelined floor square root of both squared distances, one root bit a stage
// ----------------------------------------------------------------------------
module ntsc_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [ntsc_pkg::DSQ_W-1:0]    i_d1sq,
    input  logic [ntsc_pkg::DSQ_W-1:0]    i_d2sq,
    input  ntsc_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [ntsc_pkg::ROOT_W-1:0]   o_d1,
    output logic [ntsc_pkg::ROOT_W-1:0]   o_d2,
    output ntsc_pkg::t_side               o_side
);

    localparam int NSTG  = ntsc_pkg::ROOT_W;
    localparam int PAD_W = 2 * NSTG;
    localparam int RQ_W  = ntsc_pkg::REM_W + ntsc_pkg::ROOT_W;

    // one restoring digit step: bring down two bits, try (q<<2)|1
    function automatic logic [RQ_W-1:0] root_step(
        input logic [ntsc_pkg::REM_W-1:0]  rem,
        input logic [ntsc_pkg::ROOT_W-1:0] q,
        input logic [1:0]                  pair
    );
        logic [ntsc_pkg::REM_W+1:0] sh;
        logic [ntsc_pkg::REM_W+1:0] trial;
        logic [ntsc_pkg::REM_W-1:0] rem_n;
        logic [ntsc_pkg::ROOT_W-1:0] q_n;
        sh    = {rem, pair};
        trial = {2'b00, q, 2'b01};
        if (sh >= trial) begin
            rem_n = ntsc_pkg::REM_W'(sh - trial);
            q_n   = {q[ntsc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            rem_n = ntsc_pkg::REM_W'(sh);
            q_n   = {q[ntsc_pkg::ROOT_W-2:0], 1'b0};
        end
        return {rem_n, q_n};
    endfunction

    logic                          r_vld  [NSTG];
    ntsc_pkg::t_side               r_side [NSTG];
    logic [PAD_W-1:0]              r_v1   [NSTG];
    logic [PAD_W-1:0]              r_v2   [NSTG];
    logic [ntsc_pkg::REM_W-1:0]    r_rem1 [NSTG];
    logic [ntsc_pkg::REM_W-1:0]    r_rem2 [NSTG];
    logic [ntsc_pkg::ROOT_W-1:0]   r_q1   [NSTG];
    logic [ntsc_pkg::ROOT_W-1:0]   r_q2   [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic                        w_vld;
        ntsc_pkg::t_side             w_side;
        logic [PAD_W-1:0]            w_v1;
        logic [PAD_W-1:0]            w_v2;
        logic [ntsc_pkg::REM_W-1:0]  w_rem1;
        logic [ntsc_pkg::REM_W-1:0]  w_rem2;
        logic [ntsc_pkg::ROOT_W-1:0] w_q1;
        logic [ntsc_pkg::ROOT_W-1:0] w_q2;
        logic [RQ_W-1:0]             w_step1;
        logic [RQ_W-1:0]             w_step2;

        if (s == 0) begin : g_head
            assign w_vld  = i_vld;
            assign w_side = i_side;
            assign w_v1   = PAD_W'(i_d1sq);
            assign w_v2   = PAD_W'(i_d2sq);
            assign w_rem1 = '0;
            assign w_rem2 = '0;
            assign w_q1   = '0;
            assign w_q2   = '0;
        end else begin : g_body
            assign w_vld  = r_vld[s-1];
            assign w_side = r_side[s-1];
            assign w_v1   = r_v1[s-1];
            assign w_v2   = r_v2[s-1];
            assign w_rem1 = r_rem1[s-1];
            assign w_rem2 = r_rem2[s-1];
            assign w_q1   = r_q1[s-1];
            assign w_q2   = r_q2[s-1];
        end

        assign w_step1 = root_step(w_rem1, w_q1, w_v1[PAD_W-1-2*s -: 2]);
        assign w_step2 = root_step(w_rem2, w_q2, w_v2[PAD_W-1-2*s -: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= w_side;
                r_v1[s]   <= w_v1;
                r_v2[s]   <= w_v2;
                r_rem1[s] <= w_step1[RQ_W-1 -: ntsc_pkg::REM_W];
                r_rem2[s] <= w_step2[RQ_W-1 -: ntsc_pkg::REM_W];
                r_q1[s]   <= w_step1[ntsc_pkg::ROOT_W-1:0];
                r_q2[s]   <= w_step2[ntsc_pkg::ROOT_W-1:0];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_side = r_side[NSTG-1];
    assign o_d1   = r_q1[NSTG-1];
    assign o_d2   = r_q2[NSTG-1];

endmodule

FILE: test/tb_nearest_two_seed_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_two_seed_classifier
// self-checking bench: loads seed tables, classifies cells under several
// register settings and compares every result against a scoreboard that
// recomputes nearest and second-nearest seeds with exact squared distances
// ----------------------------------------------------------------------------
module tb_nearest_two_seed_classifier;
    import ntsc_pkg::*;

    localparam int RESULT_LATENCY  = 2 * NUM_SEEDS_DEF + 19;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 130;

    // seed counts per random phase, both clamp sides included
    localparam int unsigned SEED_COUNTS [NUM_PHASES] = '{24, 2, 31, 0, 13, 1, 24, 7};
    localparam int unsigned CELL_WIDTHS [NUM_PHASES] = '{8, 1, 16, 31, 0, 5, 3, 12};
    localparam int unsigned CELL_HEIGHTS[NUM_PHASES] = '{16, 1, 31, 16, 0, 7, 2, 9};

    // input transaction layout, lowest field in the lowest bits
    typedef struct packed {
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic [COL_W-1:0]  colour;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
        logic [SLOT_W-1:0] slot;
    } stream_item_t;

    // one expected classify result
    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  colour;
        logic [CLS_W-1:0]  cls;
        logic [THR_W-1:0]  distance;
    } cell_verdict_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_THREE_OF_FOUR,
        RX_RANDOM,
        RX_LONG_STALL
    } rx_mode_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the registers and seed tables, queue of verdicts
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        logic [SIZE_W-1:0] seeds_in_use;
        logic [SIZE_W-1:0] cell_width;
        logic [SIZE_W-1:0] cell_height;
        logic [THR_W-1:0]  border_thr;
        logic [THR_W-1:0]  centre_thr;
        logic [POS_W-1:0]  seed_x      [NUM_SEEDS_DEF];
        logic [POS_W-1:0]  seed_y      [NUM_SEEDS_DEF];
        logic [COL_W-1:0]  seed_colour [NUM_SEEDS_DEF];
        bit                seed_loaded [NUM_SEEDS_DEF];
        cell_verdict_t     expected_cells [$];
        int                failures;

        function new();
            seeds_in_use = 24;
            cell_width   = 8;
            cell_height  = 16;
            border_thr   = 240;
            centre_thr   = 192;
            failures     = 0;
            foreach (seed_loaded[k]) seed_loaded[k] = 1'b0;
        endfunction

        function void set_register(logic [2:0] index, logic [31:0] value);
            case (index)
                REG_SEEDS_IN_USE: seeds_in_use = value[SIZE_W-1:0];
                REG_CELL_WIDTH:   cell_width   = value[SIZE_W-1:0];
                REG_CELL_HEIGHT:  cell_height  = value[SIZE_W-1:0];
                REG_BORDER_THR:   border_thr   = value[THR_W-1:0];
                REG_CENTRE_THR:   centre_thr   = value[THR_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        // floor square root, one result bit at a time from the top
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 20; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        function cell_verdict_t classify_cell(logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
            longint unsigned cx, cy, dx, dy, dsq, best_sq, second_sq, d1, d2;
            int              n;
            int              best;
            cell_verdict_t   v;
            // centre in q13.4: a pixel is 16, half a cell is size * 8
            cx = 64'(col) * 64'(cell_width) * 16 + 64'(cell_width) * 8;
            cy = 64'(row) * 64'(cell_height) * 16 + 64'(cell_height) * 8;
            n  = seeds_in_use;
            if (n < 2) n = 2;
            if (n > NUM_SEEDS_DEF) n = NUM_SEEDS_DEF;
            best_sq   = '1;
            second_sq = '1;
            best      = 0;
            for (int k = 0; k < n; k++) begin
                dx  = (cx >= seed_x[k]) ? cx - seed_x[k] : seed_x[k] - cx;
                dy  = (cy >= seed_y[k]) ? cy - seed_y[k] : seed_y[k] - cy;
                dsq = dx * dx + dy * dy;
                // strict compare keeps the lowest slot on a tie
                if (dsq < best_sq) begin
                    second_sq = best_sq;
                    best_sq   = dsq;
                    best      = k;
                end else if (dsq < second_sq) begin
                    second_sq = dsq;
                end
            end
            d1 = floor_root(best_sq);
            d2 = floor_root(second_sq);
            v.slot   = SLOT_W'(best);
            v.colour = seed_colour[best];
            if (d1 < centre_thr)
                v.cls = CLS_CENTRE;
            else if (d2 - d1 < border_thr)
                v.cls = CLS_BORDER;
            else
                v.cls = CLS_INTERIOR;
            v.distance = (d1 > 64'hFFFF) ? 16'hFFFF : d1[THR_W-1:0];
            return v;
        endfunction

        function void note_input(logic cmd, stream_item_t item);
            if (cmd == CMD_LOAD) begin
                // slots past the table are dropped by the block
                if (item.slot < NUM_SEEDS_DEF) begin
                    seed_x[item.slot]      = item.x;
                    seed_y[item.slot]      = item.y;
                    seed_colour[item.slot] = item.colour;
                    seed_loaded[item.slot] = 1'b1;
                end
            end else begin
                expected_cells.push_back(classify_cell(item.col, item.row));
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] word);
            cell_verdict_t want;
            if (expected_cells.size() == 0) begin
                $error("result %h with no classify outstanding", word);
                failures++;
                return;
            end
            want = expected_cells.pop_front();
            if (word[4:0] !== want.slot) begin
                $error("nearest_slot expected %0d actual %0d", want.slot, word[4:0]);
                failures++;
            end
            if (word[7:5] !== want.colour) begin
                $error("nearest_colour expected %0d actual %0d", want.colour, word[7:5]);
                failures++;
            end
            if (word[9:8] !== want.cls) begin
                $error("cell_class expected %0d actual %0d", want.cls, word[9:8]);
                failures++;
            end
            if (word[25:10] !== want.distance) begin
                $error("nearest_distance expected %0d actual %0d", want.distance,
                       word[25:10]);
                failures++;
            end
            if (word[OUT_DATA_W-1:26] !== '0) begin
                $error("zero fill expected 0 actual %h", word[OUT_DATA_W-1:26]);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // slot, x, y, colour, col, row
    logic                  s_axis_tuser  = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // slot, colour, class, distance
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [4:0]            paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    cell_scoreboard sb = new();

    int       burst_left  = 0;
    int       idle_cycles = 0;
    logic [7:0] rx_tick   = '0;
    rx_mode_t rx_mode     = RX_OPEN;

    nearest_two_seed_classifier #(
        .NUM_SEEDS(NUM_SEEDS_DEF)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 i_clk = ~i_clk;

    // monitor: both streams sampled at the edge that completes a transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, stream_item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // receiver: stall pattern picked at random each time the tick counter wraps
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '1)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:          m_axis_tready <= 1'b1;
            RX_THREE_OF_FOUR: m_axis_tready <= (rx_tick[1:0] != 2'd3);
            RX_RANDOM:        m_axis_tready <= ($urandom_range(0, 9) >= 4);
            default:          m_axis_tready <= (rx_tick[4:3] == 2'd0); // long stalls
        endcase
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // highest cell index whose centre still lies inside the seed range
    function automatic int unsigned axis_span(int unsigned size);
        int unsigned top;
        if (size == 0) return 255;
        top = (65535 - size * 8) / (size * 16);
        return (top > 255) ? 255 : top;
    endfunction

    // coordinate close to the centre of some cell along one axis
    function automatic logic [POS_W-1:0] near_centre(int unsigned size);
        int c;
        c = int'($urandom_range(0, axis_span(size))) * int'(size) * 16
            + int'(size) * 8 + int'($urandom_range(0, 80)) - 40;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        return c[POS_W-1:0];
    endfunction

    // unused fields carry random bits so every bit toggles
    function automatic stream_item_t make_load(logic [SLOT_W-1:0] slot, logic [POS_W-1:0] x,
                                               logic [POS_W-1:0] y, logic [COL_W-1:0] colour);
        logic [63:0]  raw;
        stream_item_t it;
        raw       = {$urandom, $urandom};
        it        = raw[IN_DATA_W-1:0];
        it.slot   = slot;
        it.x      = x;
        it.y      = y;
        it.colour = colour;
        return it;
    endfunction

    function automatic stream_item_t make_query(logic [CELL_W-1:0] col, logic [CELL_W-1:0] row);
        logic [63:0]  raw;
        stream_item_t it;
        raw    = {$urandom, $urandom};
        it     = raw[IN_DATA_W-1:0];
        it.col = col;
        it.row = row;
        return it;
    endfunction

    // seed load: random spot, near a cell centre, on top of another seed, or a corner
    function automatic stream_item_t random_load(logic [SLOT_W-1:0] slot);
        stream_item_t it;
        int unsigned  mode;
        int unsigned  k;
        it   = make_load(slot, POS_W'($urandom), POS_W'($urandom), COL_W'($urandom));
        mode = $urandom_range(0, 9);
        if (mode >= 3 && mode < 7) begin
            it.x = near_centre(sb.cell_width);
            it.y = near_centre(sb.cell_height);
        end else if (mode >= 7 && mode < 9) begin
            k = $urandom_range(0, NUM_SEEDS_DEF - 1);
            if (sb.seed_loaded[k]) begin
                it.x = sb.seed_x[k];
                it.y = sb.seed_y[k];
            end
        end else if (mode == 9) begin
            it.x = $urandom_range(0, 1) ? '1 : '0;
            it.y = $urandom_range(0, 1) ? '1 : '0;
        end
        return it;
    endfunction

    // mostly cells inside the seed area, sometimes anywhere on the grid
    function automatic stream_item_t random_query();
        if ($urandom_range(0, 3) == 0)
            return make_query(CELL_W'($urandom), CELL_W'($urandom));
        return make_query(CELL_W'($urandom_range(0, axis_span(sb.cell_width))),
                          CELL_W'($urandom_range(0, axis_span(sb.cell_height))));
    endfunction

    // one input transaction; bursts of random length, random gaps between
    task automatic send_item(input logic cmd, input stream_item_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold the sender until every verdict is back, then let loads clear the pipe
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 8) @(posedge i_clk);
    endtask

    // setup cycle then access cycle, register taken while pready is high
    task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pause_at;
        int unsigned scanned;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: seed count below two, so the scan clamps to the two loaded slots
        reg_write(REG_SEEDS_IN_USE, 0);
        send_item(CMD_LOAD, make_load(0, 16'h0000, 16'h0000, 3'd0)); // colour tag zero
        send_item(CMD_LOAD, make_load(1, 16'h0000, 16'h0000, 3'd7)); // tie with slot 0
        send_item(CMD_LOAD, make_load(24, 16'hFFFF, 16'hFFFF, 3'd7)); // past the table
        send_item(CMD_LOAD, make_load(31, 16'h1234, 16'h0040, 3'd5)); // past the table
        send_item(CMD_CLASSIFY, make_query(0, 0));      // tie, seed centre
        send_item(CMD_CLASSIFY, make_query(255, 255));  // tie far away, saturated, border
        send_item(CMD_LOAD, make_load(1, 16'hFFFF, 16'hFFFF, 3'd3));
        send_item(CMD_CLASSIFY, make_query(255, 255));  // far corner seed, interior
        send_item(CMD_CLASSIFY, make_query(255, 0));
        drain();

        // largest cells, thresholds at opposite extremes
        reg_write(REG_SEEDS_IN_USE, 1);
        reg_write(REG_CELL_WIDTH, 31);
        reg_write(REG_CELL_HEIGHT, 31);
        reg_write(REG_BORDER_THR, 16'hFFFF);
        reg_write(REG_CENTRE_THR, 0);
        send_item(CMD_CLASSIFY, make_query(255, 255));  // centre beyond seed range
        send_item(CMD_CLASSIFY, make_query(0, 0));
        drain();

        // zero cell size puts every centre at the origin
        reg_write(REG_CELL_WIDTH, 0);
        reg_write(REG_CELL_HEIGHT, 0);
        reg_write(REG_BORDER_THR, 0);
        send_item(CMD_LOAD, make_load(1, 16'h0000, 16'h0000, 3'd6));
        send_item(CMD_CLASSIFY, make_query(200, 17));   // equal distances, interior
        drain();
        reg_write(REG_BORDER_THR, 1);
        send_item(CMD_CLASSIFY, make_query(17, 200));   // equal distances, border
        drain();
        reg_write(REG_CENTRE_THR, 1);
        send_item(CMD_CLASSIFY, make_query(0, 255));    // distance zero, seed centre

        // random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            reg_write(REG_SEEDS_IN_USE, SEED_COUNTS[p]);
            reg_write(REG_CELL_WIDTH, CELL_WIDTHS[p]);
            reg_write(REG_CELL_HEIGHT, CELL_HEIGHTS[p]);
            case (p)
                2: begin
                    reg_write(REG_BORDER_THR, 0);
                    reg_write(REG_CENTRE_THR, 16'hFFFF);
                end
                3: begin
                    reg_write(REG_BORDER_THR, 16'hFFFF);
                    reg_write(REG_CENTRE_THR, $urandom_range(0, 1200));
                end
                4: begin
                    reg_write(REG_BORDER_THR, $urandom_range(0, 3000));
                    reg_write(REG_CENTRE_THR, 0);
                end
                6: begin
                    reg_write(REG_BORDER_THR, $urandom_range(0, 65535));
                    reg_write(REG_CENTRE_THR, $urandom_range(0, 65535));
                end
                default: begin
                    reg_write(REG_BORDER_THR, $urandom_range(0, 3000));
                    reg_write(REG_CENTRE_THR, $urandom_range(0, 1200));
                end
            endcase

            // every scanned slot is written before the first classify reads it
            scanned = SEED_COUNTS[p];
            if (scanned < 2) scanned = 2;
            if (scanned > NUM_SEEDS_DEF) scanned = NUM_SEEDS_DEF;
            for (int k = 0; k < scanned; k++) begin
                if (!sb.seed_loaded[k])
                    send_item(CMD_LOAD, random_load(SLOT_W'(k)));
            end

            pause_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // sender holds off until the result stream is empty
                if (i == pause_at)
                    drain();
                if ($urandom_range(0, 99) < 30) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(CMD_LOAD, random_load(SLOT_W'($urandom_range(NUM_SEEDS_DEF, 31))));
                    else
                        send_item(CMD_LOAD, random_load(SLOT_W'($urandom_range(0, NUM_SEEDS_DEF - 1))));
                end else begin
                    send_item(CMD_CLASSIFY, random_query());
                end
            end
        end

        drain();
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/ntsc_pkg.sv
rtl/ntsc_cell.sv
rtl/ntsc_isqrt.sv
rtl/nearest_two_seed_classifier.sv
test/tb_nearest_two_seed_classifier.sv
